// ===== hw/rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants
// Item layouts and arithmetic widths for the segment intersection unit.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int CW     = 16;            // coordinate width
  localparam int EW     = 16;            // epsilon width
  localparam int OW     = 24;            // output coordinate width
  localparam int DW     = CW + 1;        // coordinate difference
  localparam int PW     = 2 * DW;        // product of two differences
  localparam int SW     = PW + 1;        // cross product, determinant, line c
  localparam int MW     = SW + DW;       // product of line c and a difference
  localparam int NW     = MW + 1;        // Cramer numerator
  localparam int RW     = (NW > SW + OW) ? NW : SW + OW;  // divider remainder
  localparam int NPAIR  = 14;            // multiplier pairs in the front
  localparam int QDEPTH = 4;             // front-to-back queue depth
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [CW-1:0] seg_a_x0;
    logic signed [CW-1:0] seg_a_y0;
    logic signed [CW-1:0] seg_a_x1;
    logic signed [CW-1:0] seg_a_y1;
    logic signed [CW-1:0] seg_b_x0;
    logic signed [CW-1:0] seg_b_y0;
    logic signed [CW-1:0] seg_b_x1;
    logic signed [CW-1:0] seg_b_y1;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic                 parallel;
    logic signed [OW-1:0] cross_x;
    logic signed [OW-1:0] cross_y;
    logic                 overflow;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                 hit;
    logic                 par;
    logic signed [NW-1:0] num_x;
    logic signed [NW-1:0] num_y;
    logic signed [SW-1:0] det;
  } mid_t;

  // one divider stage
  typedef struct packed {
    logic          hit;
    logic          par;
    logic          neg_x;
    logic          neg_y;
    logic          big_x;
    logic          big_y;
    logic [SW-1:0] dmag;
    logic [RW-1:0] rem_x;
    logic [RW-1:0] rem_y;
    logic [OW-1:0] q_x;
    logic [OW-1:0] q_y;
  } div_t;

endpackage

// ===== hw/rtl/segment_intersection_test_unit.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test_unit: segment hit test and line crossing point
// Throughput one item per cycle while the output does not stall;
// the 24-stage quotient pipeline sets the depth.
// The front and back stall on their own through a 4-entry queue.
// Synchronous reset clears all valid state and sets epsilon to zero.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  sit_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sit_pkg::out_item_t out_item
);
  import sit_pkg::*;

  logic [15:0] epsilon;
  logic        push, pop, full, nonempty;
  mid_t        push_item, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= '0;
    end else if (cfg_wr_en) begin
      epsilon <= cfg_wr_data;
    end
  end

  sit_front u_front (
    .clk       (clk),
    .rst       (rst),
    .epsilon   (epsilon),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  sit_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (push_item),
    .pop      (pop),
    .rd_item  (head),
    .nonempty (nonempty),
    .full     (full)
  );

  sit_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (nonempty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ===== hw/rtl/sit_front.sv =====
// ----------------------------------------------------------------------------
// sit_front: orientation and line coefficient pipeline
// Five stages: differences, products, sums, classification, numerators.
// ----------------------------------------------------------------------------
module sit_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          epsilon,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sit_pkg::in_item_t    in_item,
  output logic                 push,
  output sit_pkg::mid_t        push_item,
  input  logic                 full
);
  import sit_pkg::*;

  logic                 adv;
  logic [4:0]           v;

  logic signed [DW-1:0] fa_next [NPAIR];
  logic signed [DW-1:0] fb_next [NPAIR];
  logic [3:0]           box_next;

  logic signed [DW-1:0] fa [NPAIR];
  logic signed [DW-1:0] fb [NPAIR];
  logic [3:0]           box1, box2, box3;
  logic signed [PW-1:0] prod [NPAIR];
  logic signed [DW-1:0] la2, lb2, ma2, mb2, la3, lb3, ma3, mb3;
  logic signed [SW-1:0] d3 [4];
  logic signed [SW-1:0] det3, lc3, mc3, det4, det5;
  logic signed [MW-1:0] m4 [4];
  logic                 hit4, par4, hit5, par5;
  logic signed [NW-1:0] nx5, ny5;
  logic signed [SW-1:0] eps_s;
  logic [3:0]           pos, neg;
  logic                 hit_c;

  function automatic logic signed [DW-1:0] dif(logic signed [CW-1:0] a,
                                               logic signed [CW-1:0] b);
    return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
  endfunction

  function automatic logic in_box(logic signed [CW-1:0] x0, logic signed [CW-1:0] y0,
                                  logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                                  logic signed [CW-1:0] px, logic signed [CW-1:0] py);
    logic signed [CW-1:0] xl, xh, yl, yh;
    xl = (x0 < x1) ? x0 : x1;
    xh = (x0 < x1) ? x1 : x0;
    yl = (y0 < y1) ? y0 : y1;
    yh = (y0 < y1) ? y1 : y0;
    return (xl <= px) && (px <= xh) && (yl <= py) && (py <= yh);
  endfunction

  assign adv      = !v[4] || !full;
  assign in_ready = adv;
  assign push     = v[4] && adv;

  always_comb begin
    // orientation terms
    fa_next[0]  = dif(in_item.seg_b_x0, in_item.seg_a_x1);
    fb_next[0]  = dif(in_item.seg_a_y0, in_item.seg_a_y1);
    fa_next[1]  = dif(in_item.seg_b_y0, in_item.seg_a_y1);
    fb_next[1]  = dif(in_item.seg_a_x0, in_item.seg_a_x1);
    fa_next[2]  = dif(in_item.seg_b_x1, in_item.seg_a_x1);
    fb_next[2]  = fb_next[0];
    fa_next[3]  = dif(in_item.seg_b_y1, in_item.seg_a_y1);
    fb_next[3]  = fb_next[1];
    fa_next[4]  = dif(in_item.seg_a_x0, in_item.seg_b_x1);
    fb_next[4]  = dif(in_item.seg_b_y0, in_item.seg_b_y1);
    fa_next[5]  = dif(in_item.seg_a_y0, in_item.seg_b_y1);
    fb_next[5]  = dif(in_item.seg_b_x0, in_item.seg_b_x1);
    fa_next[6]  = dif(in_item.seg_a_x1, in_item.seg_b_x1);
    fb_next[6]  = fb_next[4];
    fa_next[7]  = dif(in_item.seg_a_y1, in_item.seg_b_y1);
    fb_next[7]  = fb_next[5];
    // line terms: la = a.y0-a.y1, lb = a.x1-a.x0, same for m
    fa_next[8]  = dif(in_item.seg_a_y0, in_item.seg_a_y1);
    fb_next[8]  = dif(in_item.seg_b_x1, in_item.seg_b_x0);
    fa_next[9]  = dif(in_item.seg_b_y0, in_item.seg_b_y1);
    fb_next[9]  = dif(in_item.seg_a_x1, in_item.seg_a_x0);
    fa_next[10] = fa_next[8];
    fb_next[10] = $signed({in_item.seg_a_x0[CW-1], in_item.seg_a_x0});
    fa_next[11] = fb_next[9];
    fb_next[11] = $signed({in_item.seg_a_y0[CW-1], in_item.seg_a_y0});
    fa_next[12] = fa_next[9];
    fb_next[12] = $signed({in_item.seg_b_x0[CW-1], in_item.seg_b_x0});
    fa_next[13] = fb_next[8];
    fb_next[13] = $signed({in_item.seg_b_y0[CW-1], in_item.seg_b_y0});
    box_next[0] = in_box(in_item.seg_a_x0, in_item.seg_a_y0, in_item.seg_a_x1,
                         in_item.seg_a_y1, in_item.seg_b_x0, in_item.seg_b_y0);
    box_next[1] = in_box(in_item.seg_a_x0, in_item.seg_a_y0, in_item.seg_a_x1,
                         in_item.seg_a_y1, in_item.seg_b_x1, in_item.seg_b_y1);
    box_next[2] = in_box(in_item.seg_b_x0, in_item.seg_b_y0, in_item.seg_b_x1,
                         in_item.seg_b_y1, in_item.seg_a_x0, in_item.seg_a_y0);
    box_next[3] = in_box(in_item.seg_b_x0, in_item.seg_b_y0, in_item.seg_b_x1,
                         in_item.seg_b_y1, in_item.seg_a_x1, in_item.seg_a_y1);
  end

  always_comb begin
    eps_s = $signed({{(SW-EW){1'b0}}, epsilon});
    for (int k = 0; k < 4; k++) begin
      pos[k] = d3[k] > eps_s;
      neg[k] = d3[k] < -eps_s;
    end
    hit_c = ((neg[0] && pos[1]) || (pos[0] && neg[1])) &&
            ((neg[2] && pos[3]) || (pos[2] && neg[3]));
    for (int k = 0; k < 4; k++) begin
      if (!pos[k] && !neg[k] && box3[k]) begin
        hit_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fa   <= fa_next;
      fb   <= fb_next;
      box1 <= box_next;
      for (int k = 0; k < NPAIR; k++) begin
        prod[k] <= fa[k] * fb[k];
      end
      box2 <= box1;
      la2  <= fa[8];
      ma2  <= fa[9];
      lb2  <= fb[9];
      mb2  <= fb[8];
      for (int k = 0; k < 4; k++) begin
        d3[k] <= SW'(prod[2*k]) - SW'(prod[2*k+1]);
      end
      det3 <= SW'(prod[8]) - SW'(prod[9]);
      lc3  <= SW'(prod[10]) + SW'(prod[11]);
      mc3  <= SW'(prod[12]) + SW'(prod[13]);
      box3 <= box2;
      la3  <= la2;
      lb3  <= lb2;
      ma3  <= ma2;
      mb3  <= mb2;
      m4[0] <= lc3 * mb3;
      m4[1] <= mc3 * lb3;
      m4[2] <= mc3 * la3;
      m4[3] <= lc3 * ma3;
      hit4 <= hit_c;
      par4 <= (det3 == '0);
      det4 <= det3;
      nx5  <= NW'(m4[0]) - NW'(m4[1]);
      ny5  <= NW'(m4[2]) - NW'(m4[3]);
      hit5 <= hit4;
      par5 <= par4;
      det5 <= det4;
    end
  end

  always_comb begin
    push_item.hit   = hit5;
    push_item.par   = par5;
    push_item.num_x = nx5;
    push_item.num_y = ny5;
    push_item.det   = det5;
  end

endmodule

// ===== hw/rtl/sit_fifo.sv =====
// ----------------------------------------------------------------------------
// sit_fifo: short queue between front and back
// Register-based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module sit_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sit_pkg::mid_t wr_item,
  input  logic          pop,
  output sit_pkg::mid_t rd_item,
  output logic          nonempty,
  output logic          full
);
  import sit_pkg::*;

  mid_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign nonempty = (count != '0);
  assign full     = (count == (QAW+1)'(QDEPTH));
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== hw/rtl/sit_back.sv =====
// ----------------------------------------------------------------------------
// sit_back: pipelined divide and saturate
// Two restoring dividers, one quotient bit per stage, then output register.
// ----------------------------------------------------------------------------
module sit_back (
  input  logic               clk,
  input  logic               rst,
  input  sit_pkg::mid_t      head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sit_pkg::out_item_t out_item
);
  import sit_pkg::*;

  div_t          st [OW+1];
  div_t          st_in;
  div_t          st_nx [OW];
  logic [OW:0]   v;
  logic          adv, out_load;
  logic [NW-1:0] nmag_x, nmag_y;
  logic [SW-1:0] dmag;
  logic [RW-1:0] sh;
  logic          ovf_x, ovf_y;
  logic [OW-1:0] res_x, res_y;

  assign out_load = !out_valid || out_ready;
  assign adv      = out_load || !v[OW];
  assign pop      = head_valid && adv;

  always_comb begin
    nmag_x = head.num_x[NW-1] ? NW'(-head.num_x) : NW'(head.num_x);
    nmag_y = head.num_y[NW-1] ? NW'(-head.num_y) : NW'(head.num_y);
    dmag   = head.det[SW-1] ? SW'(-head.det) : SW'(head.det);
    st_in.hit   = head.hit;
    st_in.par   = head.par;
    st_in.neg_x = head.num_x[NW-1] ^ head.det[SW-1];
    st_in.neg_y = head.num_y[NW-1] ^ head.det[SW-1];
    // quotient needs more than OW bits
    st_in.big_x = {RW'(dmag), OW'(0)} <= {OW'(0), RW'(nmag_x)};
    st_in.big_y = {RW'(dmag), OW'(0)} <= {OW'(0), RW'(nmag_y)};
    st_in.dmag  = dmag;
    st_in.rem_x = RW'(nmag_x);
    st_in.rem_y = RW'(nmag_y);
    st_in.q_x   = '0;
    st_in.q_y   = '0;
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    sh = '0;
    for (int k = 0; k < OW; k++) begin
      sh       = RW'(st[k].dmag) << (OW - 1 - k);
      st_nx[k] = st[k];
      if (st[k].rem_x >= sh) begin
        st_nx[k].rem_x         = st[k].rem_x - sh;
        st_nx[k].q_x[OW-1-k]   = 1'b1;
      end
      if (st[k].rem_y >= sh) begin
        st_nx[k].rem_y         = st[k].rem_y - sh;
        st_nx[k].q_y[OW-1-k]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[OW-1:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st_in;
      for (int k = 0; k < OW; k++) begin
        st[k+1] <= st_nx[k];
      end
    end
  end

  function automatic logic [OW:0] fit(logic [OW-1:0] q, logic neg, logic big);
    logic [OW-1:0] lim, mag;
    logic          ovf;
    lim = neg ? {1'b1, (OW-1)'(0)} : {1'b0, {(OW-1){1'b1}}};
    ovf = big || (q > lim);
    mag = ovf ? lim : q;
    return {ovf, neg ? OW'(-mag) : mag};
  endfunction

  always_comb begin
    {ovf_x, res_x} = fit(st[OW].q_x, st[OW].neg_x, st[OW].big_x);
    {ovf_y, res_y} = fit(st[OW].q_y, st[OW].neg_y, st[OW].big_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= v[OW];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.hit      <= st[OW].hit;
      out_item.parallel <= st[OW].par;
      out_item.cross_x  <= st[OW].par ? '0 : $signed(res_x);
      out_item.cross_y  <= st[OW].par ? '0 : $signed(res_y);
      out_item.overflow <= !st[OW].par && (ovf_x || ovf_y);
    end
  end

endmodule

// ===== hw/rtl/sit_checker.sv =====
// ----------------------------------------------------------------------------
// sit_checker: port-level checks
// Watches the top level output channel and result consistency.
// ----------------------------------------------------------------------------
module sit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sit_pkg::out_item_t out_item
);
  import sit_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item dropped while stalled");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_par: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.parallel |->
      out_item.cross_x == '0 && out_item.cross_y == '0 && !out_item.overflow)
    else $error("parallel item with nonzero point");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.overflow |->
      out_item.cross_x == 24'sh7FFFFF || out_item.cross_x == 24'sh800000 ||
      out_item.cross_y == 24'sh7FFFFF || out_item.cross_y == 24'sh800000)
    else $error("overflow without a saturated coordinate");

endmodule

bind segment_intersection_test_unit sit_checker u_sit_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== dv/tb_segment_intersection_test_unit.sv =====
// ----------------------------------------------------------------------------
// tb_segment_intersection_test_unit: self-checking bench for the segment unit
// Drives segment pairs through valid/ready with random gaps on both sides,
// predicts hit, parallel, crossing point and overflow in wide integer math,
// and compares every result in order. Epsilon is swept between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segment_intersection_test_unit;
  import sit_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 64;
  localparam longint unsigned OUT_MAX = 64'd8388607;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;

  logic [15:0] eps_reg = '0;
  out_item_t   pending_results[$];
  int          fail_count = 0;
  int          idle_cycles = 0;

  segment_intersection_test_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #1 clk = ~clk;

  function automatic logic signed [127:0] orient(
      longint ax, longint ay, longint bx, longint by, longint cx, longint cy);
    logic signed [127:0] t1, t2;
    t1 = 128'(cx - bx) * 128'(ay - by);
    t2 = 128'(cy - by) * 128'(ax - bx);
    return t1 - t2;
  endfunction

  function automatic bit in_box(longint x0, longint y0, longint x1, longint y1,
                                longint px, longint py);
    longint xl, xh, yl, yh;
    xl = (x0 < x1) ? x0 : x1; xh = (x0 < x1) ? x1 : x0;
    yl = (y0 < y1) ? y0 : y1; yh = (y0 < y1) ? y1 : y0;
    return xl <= px && px <= xh && yl <= py && py <= yh;
  endfunction

  // truncating quotient, clamped to the 24-bit output range
  function automatic logic [OW-1:0] clamp_quot(logic signed [127:0] num,
      logic signed [127:0] den, inout bit ovf);
    logic [127:0] n, d, q;
    bit neg;
    longint unsigned lim;
    logic [127:0] mag;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    lim = neg ? OUT_MAX + 1 : OUT_MAX;
    if (q > 128'(lim)) begin
      ovf = 1'b1;
      mag = 128'(lim);
    end else begin
      mag = q;
    end
    if (neg) mag = -mag;
    return mag[OW-1:0];
  endfunction

  function automatic out_item_t predict_crossing(in_item_t s);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic signed [127:0] d[4], ep, la, lb, lc, ma, mb, mc, det;
    bit p[4], n[4], hit, ovf;
    out_item_t r;
    ax0 = s.seg_a_x0; ay0 = s.seg_a_y0; ax1 = s.seg_a_x1; ay1 = s.seg_a_y1;
    bx0 = s.seg_b_x0; by0 = s.seg_b_y0; bx1 = s.seg_b_x1; by1 = s.seg_b_y1;
    d[0] = orient(ax0, ay0, ax1, ay1, bx0, by0);
    d[1] = orient(ax0, ay0, ax1, ay1, bx1, by1);
    d[2] = orient(bx0, by0, bx1, by1, ax0, ay0);
    d[3] = orient(bx0, by0, bx1, by1, ax1, ay1);
    ep = 128'(eps_reg);
    for (int i = 0; i < 4; i++) begin
      p[i] = d[i] > ep;
      n[i] = d[i] < -ep;
    end
    hit = ((n[0] && p[1]) || (p[0] && n[1])) && ((n[2] && p[3]) || (p[2] && n[3]));
    if (!p[0] && !n[0] && in_box(ax0, ay0, ax1, ay1, bx0, by0)) hit = 1'b1;
    if (!p[1] && !n[1] && in_box(ax0, ay0, ax1, ay1, bx1, by1)) hit = 1'b1;
    if (!p[2] && !n[2] && in_box(bx0, by0, bx1, by1, ax0, ay0)) hit = 1'b1;
    if (!p[3] && !n[3] && in_box(bx0, by0, bx1, by1, ax1, ay1)) hit = 1'b1;
    la = 128'(ay0 - ay1); lb = 128'(ax1 - ax0);
    lc = la * 128'(ax0) + lb * 128'(ay0);
    ma = 128'(by0 - by1); mb = 128'(bx1 - bx0);
    mc = ma * 128'(bx0) + mb * 128'(by0);
    det = la * mb - ma * lb;
    ovf = 1'b0;
    r.hit = hit;
    if (det == 0) begin
      r.parallel = 1'b1;
      r.cross_x = '0;
      r.cross_y = '0;
    end else begin
      r.parallel = 1'b0;
      r.cross_x = clamp_quot(lc * mb - mc * lb, det, ovf);
      r.cross_y = clamp_quot(la * mc - ma * lc, det, ovf);
    end
    r.overflow = ovf;
    return r;
  endfunction

  // valid stays high after an accept so a gapless next item follows at once;
  // it drops when a gap is drawn or when the sender waits for the drain
  task automatic send_segments(in_item_t s, bit allow_gap = 1'b1);
    int gap;
    gap = allow_gap ? $urandom_range(0, 19) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_crossing(s));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [15:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    eps_reg = v;
  endtask

  function automatic in_item_t make_segs(int ax0, int ay0, int ax1, int ay1,
                                         int bx0, int by0, int bx1, int by1);
    in_item_t s;
    s.seg_a_x0 = 16'(ax0); s.seg_a_y0 = 16'(ay0);
    s.seg_a_x1 = 16'(ax1); s.seg_a_y1 = 16'(ay1);
    s.seg_b_x0 = 16'(bx0); s.seg_b_y0 = 16'(by0);
    s.seg_b_x1 = 16'(bx1); s.seg_b_y1 = 16'(by1);
    return s;
  endfunction

  function automatic in_item_t random_segs();
    in_item_t s;
    int sz;
    s = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;  // full-range noise
      1, 2: begin  // small coordinates, many hits
        sz = $urandom_range(2, 200);
        s = make_segs($urandom_range(0, 2*sz) - sz, $urandom_range(0, 2*sz) - sz,
                      $urandom_range(0, 2*sz) - sz, $urandom_range(0, 2*sz) - sz,
                      $urandom_range(0, 2*sz) - sz, $urandom_range(0, 2*sz) - sz,
                      $urandom_range(0, 2*sz) - sz, $urandom_range(0, 2*sz) - sz);
      end
      3: begin  // shared endpoint
        s.seg_b_x0 = s.seg_a_x1;
        s.seg_b_y0 = s.seg_a_y1;
      end
      4: begin  // parallel via scaled direction
        s.seg_a_x0 = $signed(16'($urandom)) >>> 2; s.seg_a_y0 = $signed(16'($urandom)) >>> 2;
        s.seg_a_x1 = s.seg_a_x0 + 16'($urandom_range(0, 40)) - 16'd20;
        s.seg_a_y1 = s.seg_a_y0 + 16'($urandom_range(0, 40)) - 16'd20;
        s.seg_b_x0 = s.seg_a_x0 + 16'($urandom_range(0, 20));
        s.seg_b_y0 = s.seg_a_y0 + 16'($urandom_range(0, 20));
        s.seg_b_x1 = s.seg_b_x0 + 16'(2 * (s.seg_a_x1 - s.seg_a_x0));
        s.seg_b_y1 = s.seg_b_y0 + 16'(2 * (s.seg_a_y1 - s.seg_a_y0));
      end
      default: begin  // nearly parallel, b shifted slightly from a
        s.seg_b_x0 = s.seg_a_x0 + 16'd1;
        s.seg_b_y0 = s.seg_a_y0;
        s.seg_b_x1 = s.seg_a_x1;
        s.seg_b_y1 = s.seg_a_y1 + 16'($urandom_range(0, 2));
      end
    endcase
    return s;
  endfunction

  task automatic test_directed();
    send_segments(make_segs(-16, 0, 16, 0, 0, -16, 0, 16));        // proper cross
    send_segments(make_segs(0, 0, 16, 0, 32, -16, 32, 16));        // miss
    send_segments(make_segs(0, 0, 16, 16, 16, 16, 32, 0));         // shared endpoint
    send_segments(make_segs(0, 0, 32, 0, 16, 0, 48, 0));           // collinear overlap
    send_segments(make_segs(0, 0, 16, 0, 32, 0, 48, 0));           // collinear disjoint
    send_segments(make_segs(0, 0, 16, 0, 0, 8, 16, 8));            // parallel
    send_segments(make_segs(5, 5, 5, 5, 5, 5, 5, 5));              // point segments
    send_segments(make_segs(0, 0, 32, 0, 16, 0, 16, 16));          // T touch
    send_segments(make_segs(-32768, -32768, 32767, 32767,
                            -32768, 32767, 32767, -32768));        // extreme diagonals
    send_segments(make_segs(32767, 32767, 32767, 32767,
                            -32768, -32768, -32768, -32768));
    send_segments(make_segs(-32768, 0, 32767, 1, -32768, 1, 32767, 0));
    send_segments(make_segs(-32768, -32768, 32767, -32767,
                            -32768, -32767, 32767, -32768));
    send_segments(make_segs(0, 0, 1, 0, 0, 1, 32767, 2));          // far crossing point
    send_segments(make_segs(0, 0, 32767, 1, 0, 1, 32767, 2));
    send_segments(make_segs(-1, -1, -1, -1, -1, -1, 0, 0));
    send_segments(make_segs(0, 0, 16, 1, 0, 1, 16, 0));
  endtask

  task automatic test_epsilon_sweep();
    logic [15:0] eps_vals[5] = '{16'd1, 16'd256, 16'd4000, 16'hFFFF, 16'd0};
    foreach (eps_vals[i]) begin
      write_epsilon(eps_vals[i]);
      send_segments(make_segs(0, 0, 64, 0, 10, 1, 10, 40));        // near-touch
      send_segments(make_segs(0, 0, 64, 0, 10, -1, 10, 40));
      send_segments(make_segs(0, 0, 64, 0, 70, 1, 80, 2));
      repeat (40) send_segments(random_segs());
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < 800; i++) begin
      if (i == 400) wait_drained();  // sender holds off until the pipe is empty
      send_segments(random_segs(), (i % 200) >= 50);
    end
    write_epsilon(16'd0);
  endtask

  // result sink with random stalls
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (!rst && out_ready && out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          out_item_t exp_r;
          exp_r = pending_results.pop_front();
          if (out_item.hit !== exp_r.hit) begin
            $error("hit exp %0d got %0d", exp_r.hit, out_item.hit); fail_count++;
          end
          if (out_item.parallel !== exp_r.parallel) begin
            $error("parallel exp %0d got %0d", exp_r.parallel, out_item.parallel);
            fail_count++;
          end
          if (out_item.cross_x !== exp_r.cross_x) begin
            $error("cross_x exp %0d got %0d", exp_r.cross_x, out_item.cross_x);
            fail_count++;
          end
          if (out_item.cross_y !== exp_r.cross_y) begin
            $error("cross_y exp %0d got %0d", exp_r.cross_y, out_item.cross_y);
            fail_count++;
          end
          if (out_item.overflow !== exp_r.overflow) begin
            $error("overflow exp %0d got %0d", exp_r.overflow, out_item.overflow);
            fail_count++;
          end
        end
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end else if (!rst) begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      idle_cycles <= 0;
    else if (pending_results.size() != 0 || in_valid)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_segment_intersection_test_unit: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_epsilon_sweep();
    test_random();
    wait_drained();
    if (fail_count == 0) begin
      $display("tb_segment_intersection_test_unit: PASS");
    end else begin
      $display("tb_segment_intersection_test_unit: FAIL");
    end
    $finish;
  end

endmodule
